FILE: hw/rtl/nqs_pkg.sv
package nqs_pkg;

    localparam int BOARD_W      = 5;
    localparam int COL_W        = 4;
    localparam int PLACE_W      = 64;
    localparam int MAX_SIZE_DEF = 16;

    localparam logic [BOARD_W-1:0] BOARD_RESET = 5'd8;

    // Per-cell control: sel marks the cell of the current row, step lets it commit.
    typedef struct packed {
        logic sel;
        logic step;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/nqs_req_if.sv
interface nqs_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

FILE: hw/rtl/nqs_res_if.sv
interface nqs_res_if;
    import nqs_pkg::*;

    logic               valid;
    logic               ready;
    logic [PLACE_W-1:0] placement;
    logic               found;

    modport source (output valid, output placement, output found, input ready);
    modport sink   (input valid, input placement, input found, output ready);
endinterface

FILE: hw/rtl/nqs_cell.sv
module nqs_cell #(
    parameter int MAX_SIZE = nqs_pkg::MAX_SIZE_DEF,
    parameter int ROW_W    = $clog2(MAX_SIZE + 1)
) (
    input  logic                       i_clk,
    input  nqs_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_load,
    input  logic [MAX_SIZE-1:0]        i_col_mask,
    input  logic [MAX_SIZE-1:0]        i_ld_mask,
    input  logic [MAX_SIZE-1:0]        i_rd_mask,
    input  logic [MAX_SIZE-1:0]        i_valid_cols,
    output logic                       o_has,
    output logic                       o_fwd,
    output logic [MAX_SIZE-1:0]        o_col_mask,
    output logic [MAX_SIZE-1:0]        o_ld_mask,
    output logic [MAX_SIZE-1:0]        o_rd_mask,
    output logic [nqs_pkg::COL_W-1:0]  o_col
);
    import nqs_pkg::*;

    logic [MAX_SIZE-1:0] r_col_mask;
    logic [MAX_SIZE-1:0] r_ld_mask;
    logic [MAX_SIZE-1:0] r_rd_mask;
    logic [ROW_W-1:0]    r_start;
    logic [COL_W-1:0]    r_col;

    logic [MAX_SIZE-1:0] ge_start;
    logic [MAX_SIZE-1:0] avail;
    logic [MAX_SIZE-1:0] pick_oh;
    logic [COL_W-1:0]    pick;

    // Candidates: free of all three attack masks, on the board, at or past the resume point.
    always_comb begin
        for (int j = 0; j < MAX_SIZE; j++) begin
            ge_start[j] = (ROW_W'(j) >= r_start);
        end
        avail   = ~(r_col_mask | r_ld_mask | r_rd_mask) & i_valid_cols & ge_start;
        pick_oh = avail & (~avail + MAX_SIZE'(1));
        pick    = '0;
        for (int j = 0; j < MAX_SIZE; j++) begin
            if (pick_oh[j]) begin
                pick = COL_W'(j);
            end
        end
    end

    assign o_has      = |avail;
    assign o_fwd      = i_ctl.sel && i_ctl.step && o_has;
    // Attack masks seen by the next row down.
    assign o_col_mask = r_col_mask | pick_oh;
    assign o_ld_mask  = (r_ld_mask | pick_oh) << 1;
    assign o_rd_mask  = (r_rd_mask | pick_oh) >> 1;
    assign o_col      = r_col;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_col_mask <= i_col_mask;
            r_ld_mask  <= i_ld_mask;
            r_rd_mask  <= i_rd_mask;
            r_start    <= '0;
        end else if (o_fwd) begin
            r_col   <= pick;
            r_start <= ROW_W'({1'b0, pick}) + ROW_W'(1);
        end
    end

endmodule

FILE: hw/rtl/n_queens_solution_enumerator_unit.sv
// Search: once a request is taken the unit walks the tree node by node, each node a place or
//   backtrack step; an exhausted search answers without a step. The result is registered
//   once the result register is free, and the search holds until then.
// Throughput: one request at a time; the next request can be taken as soon as the result
//   appears, and the single active row cell sets the pace at one step per cycle.
// Reset: board size returns to 8, the search returns to the empty board, no result pending.
module n_queens_solution_enumerator_unit #(
    parameter int MAX_SIZE = nqs_pkg::MAX_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    nqs_req_if.sink                      i_req,
    nqs_res_if.source                    o_res,
    input  logic                         i_cfg_we,
    input  logic [nqs_pkg::BOARD_W-1:0]  i_cfg_wdata
);
    import nqs_pkg::*;

    localparam int ROW_W = $clog2(MAX_SIZE + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    t_state               r_state;
    logic [BOARD_W-1:0]   r_board;
    logic [ROW_W-1:0]     r_row;      // depth of the row stack
    logic                 r_started;
    logic                 r_exh;
    logic                 r_out_valid;
    logic [PLACE_W-1:0]   r_placement;
    logic                 r_found;

    logic [ROW_W-1:0]     n_size;
    logic [MAX_SIZE-1:0]  valid_cols;
    t_cell_ctl            cell_ctl [MAX_SIZE];
    logic                 cell_load [MAX_SIZE];
    logic                 cell_has [MAX_SIZE];
    logic                 cell_fwd [MAX_SIZE];
    logic [MAX_SIZE-1:0]  chain_col [MAX_SIZE];
    logic [MAX_SIZE-1:0]  chain_ld [MAX_SIZE];
    logic [MAX_SIZE-1:0]  chain_rd [MAX_SIZE];
    logic [COL_W-1:0]     cell_col [MAX_SIZE];

    logic                 accept;
    logic                 fresh;
    logic                 searching;
    logic                 at_goal;
    logic                 sel_has;
    logic                 done;
    logic                 out_free;
    logic [PLACE_W-1:0]   packed_cols;

    // Clamp the board to the number of cells built.
    assign n_size = (r_board > BOARD_W'(MAX_SIZE)) ? ROW_W'(MAX_SIZE) : ROW_W'(r_board);

    assign accept    = i_req.valid && i_req.ready;
    // A board size write in the same cycle restarts the search as well.
    assign fresh     = i_req.restart || !r_started || i_cfg_we;
    assign searching = (r_state == ST_SEARCH);
    assign at_goal   = (r_row == n_size);
    assign out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        for (int j = 0; j < MAX_SIZE; j++) begin
            valid_cols[j] = (ROW_W'(j) < n_size);
        end
    end

    // Each cell owns one row: stored column, resume point and incoming attack masks.
    // Placing a queen hands the updated masks to the next cell in the same cycle.
    for (genvar g = 0; g < MAX_SIZE; g++) begin : g_cell
        assign cell_ctl[g].sel  = (r_row == ROW_W'(g));
        assign cell_ctl[g].step = searching && !r_exh && !at_goal;

        if (g == 0) begin : g_head
            assign cell_load[g] = accept && fresh;
            nqs_cell #(.MAX_SIZE(MAX_SIZE), .ROW_W(ROW_W)) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl[g]),
                .i_load       (cell_load[g]),
                .i_col_mask   ('0),
                .i_ld_mask    ('0),
                .i_rd_mask    ('0),
                .i_valid_cols (valid_cols),
                .o_has        (cell_has[g]),
                .o_fwd        (cell_fwd[g]),
                .o_col_mask   (chain_col[g]),
                .o_ld_mask    (chain_ld[g]),
                .o_rd_mask    (chain_rd[g]),
                .o_col        (cell_col[g])
            );
        end else begin : g_body
            assign cell_load[g] = cell_fwd[g-1];
            nqs_cell #(.MAX_SIZE(MAX_SIZE), .ROW_W(ROW_W)) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl[g]),
                .i_load       (cell_load[g]),
                .i_col_mask   (chain_col[g-1]),
                .i_ld_mask    (chain_ld[g-1]),
                .i_rd_mask    (chain_rd[g-1]),
                .i_valid_cols (valid_cols),
                .o_has        (cell_has[g]),
                .o_fwd        (cell_fwd[g]),
                .o_col_mask   (chain_col[g]),
                .o_ld_mask    (chain_ld[g]),
                .o_rd_mask    (chain_rd[g]),
                .o_col        (cell_col[g])
            );
        end
    end

    // Gather the active cell's verdict and pack the board; rows off the board read as zero.
    always_comb begin
        sel_has     = 1'b0;
        packed_cols = '0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            sel_has = sel_has | (cell_has[i] & cell_ctl[i].sel);
            if (ROW_W'(i) < n_size) begin
                packed_cols[COL_W*i +: COL_W] = cell_col[i];
            end
        end
    end

    // Finish on a full board, on a dead end at row zero, or at once when exhausted.
    assign done = searching && (r_exh || at_goal || (!sel_has && (r_row == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_board     <= BOARD_RESET;
            r_row       <= '0;
            r_started   <= 1'b0;
            r_exh       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one replaces it this cycle
            if (r_out_valid && o_res.ready && !done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_we) begin
                        r_board <= i_cfg_wdata;
                    end
                    if (accept) begin
                        r_state <= ST_SEARCH;
                        if (fresh) begin
                            r_started <= 1'b1;
                            r_exh     <= 1'b0;
                            r_row     <= '0;
                        end else if (!r_exh) begin
                            // resume from the last row of the previous solution
                            if (r_row == '0) begin
                                r_exh <= 1'b1;
                            end else begin
                                r_row <= r_row - ROW_W'(1);
                            end
                        end
                    end else if (i_cfg_we) begin
                        // a new board size drops the old search
                        r_started <= 1'b0;
                        r_exh     <= 1'b0;
                    end
                end
                ST_SEARCH: begin
                    if (done) begin
                        // hold the search until the result register frees up
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_found     <= at_goal && !r_exh;
                            r_placement <= (at_goal && !r_exh) ? packed_cols : '0;
                            if (!r_exh && !at_goal) begin
                                r_exh <= 1'b1;
                                r_row <= '0;
                            end
                            r_state <= ST_IDLE;
                        end
                    end else if (sel_has) begin
                        r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_row <= r_row - ROW_W'(1);
                    end
                end
            endcase
        end
    end

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.placement = r_placement;
    assign o_res.found     = r_found;

endmodule

FILE: hw/rtl/nqs_checker.sv
module nqs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic                        i_res_found,
    input logic [nqs_pkg::PLACE_W-1:0] i_res_placement
);
    import nqs_pkg::*;

    // Reset leaves no result pending.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its contents.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_placement)
            && $stable(i_res_found))
        else $error("stalled result changed");

    // Exhausted answers carry an empty board.
    a_empty_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_found |-> i_res_placement == '0)
        else $error("placement set without a solution");

    // One request at a time: the search closes the request side.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken during a search");

    // A new result only ever comes out of a running search.
    a_res_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> !$past(i_req_ready))
        else $error("result appeared without a search");

endmodule

bind n_queens_solution_enumerator_unit nqs_checker u_nqs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_found     (o_res.found),
    .i_res_placement (o_res.placement)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import nqs_pkg::*;

    // Shadow copy of the solver plus the list of solutions still owed by the block.
    class queens_tracker;
        typedef struct {
            logic [PLACE_W-1:0] placement;
            logic               found;
        } t_solution;

        logic [BOARD_W-1:0] board_size = BOARD_RESET;
        logic [COL_W-1:0]   col_of_row [MAX_SIZE_DEF];
        int                 depth = 0;
        bit                 exhausted = 0;
        bit                 started = 0;
        t_solution          solutions_due[$];
        int                 errors = 0;

        function void clear_search();
            depth = 0;
            exhausted = 0;
            started = 0;
        endfunction

        function void set_board_size(logic [BOARD_W-1:0] value);
            board_size = value;
            clear_search();
        endfunction

        function int board_rows();
            return (board_size > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(board_size);
        endfunction

        function bit col_free(int col, int row);
            int c;
            for (int i = 0; i < row; i++) begin
                c = int'(col_of_row[i]);
                if (col == c || col + i == c + row || col + row == c + i)
                    return 0;
            end
            return 1;
        endfunction

        // Depth-first walk from (row, col); returns 1 when a full board is placed.
        function bit advance(int row, int col, int n);
            while (1) begin
                if (row >= n) begin
                    depth = n;
                    return 1;
                end
                while (col < n && !col_free(col, row))
                    col++;
                if (col < n) begin
                    col_of_row[row] = COL_W'(col);
                    row++;
                    col = 0;
                end else begin
                    if (row == 0)
                        return 0;
                    row--;
                    col = int'(col_of_row[row]) + 1;
                end
            end
        endfunction

        function int pending();
            return solutions_due.size();
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task note_request(bit restart);
            int                 n;
            int                 r;
            bit                 ok;
            logic [PLACE_W-1:0] packed_cols;
            t_solution          s;
            n = board_rows();
            ok = 0;
            packed_cols = '0;
            if (restart)
                clear_search();
            if (!exhausted) begin
                if (!started) begin
                    started = 1;
                    ok = advance(0, 0, n);
                end else if (depth > 0 && depth <= n) begin
                    r = depth - 1;
                    ok = advance(r, int'(col_of_row[r]) + 1, n);
                end
                if (!ok) begin
                    exhausted = 1;
                    depth = 0;
                end
            end
            if (ok)
                for (r = 0; r < n; r++)
                    packed_cols |= PLACE_W'(col_of_row[r]) << (COL_W * r);
            s.placement = packed_cols;
            s.found = ok;
            solutions_due.push_back(s);
        endtask

        task check_result(logic [PLACE_W-1:0] placement, logic found);
            t_solution s;
            if (solutions_due.size() == 0) begin
                report($sformatf("result %h found %b with no request outstanding",
                                 placement, found));
                return;
            end
            s = solutions_due.pop_front();
            if (placement !== s.placement)
                report($sformatf("placement %h, expected %h", placement, s.placement));
            if (found !== s.found)
                report($sformatf("found %b, expected %b", found, s.found));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [BOARD_W-1:0] cfg_wdata;
    logic               sink_ready = 1'b0;
    int                 stall_left = 0;
    bit                 calm = 0;      // set for the tail of the run: no idling at all

    queens_tracker sb = new;

    nqs_req_if req_if ();
    nqs_res_if res_if ();

    assign res_if.ready = sink_ready;

    n_queens_solution_enumerator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check every accepted result, then decide whether to stall the next cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && sink_ready)
            sb.check_result(res_if.placement, res_if.found);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            // Drop ready and start a stall burst.
            stall_left <= $urandom_range(0, 18);
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    // Hold until every owed solution has come back.
    task wait_drain();
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    // Lower valid after the last request of a group and let the results drain.
    task settle();
        req_if.valid <= 1'b0;
        wait_drain();
    endtask

    // Write the board size while the solver is idle; the predictor restarts with it.
    task write_board_size(logic [BOARD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_board_size(value);
    endtask

    // Present one request. Valid stays high after acceptance so that back-to-back
    // requests never lower and raise it in the same step; settle() lowers it.
    task send_request(bit restart);
        int gap;
        bit hold_off;
        gap = 0;
        hold_off = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (!calm && $urandom_range(0, 11) == 0)
            hold_off = 1;
        if (gap > 0 || hold_off) begin
            req_if.valid <= 1'b0;
            if (hold_off) begin
                // Pause the sender until the block has answered everything.
                @(posedge i_clk);
                wait_drain();
            end
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.restart <= restart;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        sb.note_request(restart);
    endtask

    task burst(int count, bit restart);
        repeat (count) send_request(restart);
    endtask

    initial begin
        int                 sent;
        int                 pick;
        int                 count;
        logic [BOARD_W-1:0] size_pick;

        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.restart <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset board of 8: first two solutions, then restart back to the first.
        burst(2, 0);
        send_request(1);
        settle();

        // Empty board: one empty solution, then exhausted until a restart.
        write_board_size(BOARD_W'(0));
        burst(3, 0);
        send_request(1);
        settle();

        // Single square, then the sizes that have no solution at all.
        write_board_size(BOARD_W'(1));
        burst(2, 0);
        settle();
        write_board_size(BOARD_W'(2));
        burst(2, 0);
        settle();
        write_board_size(BOARD_W'(3));
        burst(1, 0);
        settle();

        // Both solutions of the 4 by 4 board, exhaustion, restart.
        write_board_size(BOARD_W'(4));
        burst(3, 0);
        send_request(1);
        settle();

        // Largest board, and an oversized value that must clamp to it.
        write_board_size(BOARD_W'(16));
        burst(2, 0);
        settle();
        write_board_size(BOARD_W'(31));
        burst(1, 0);
        settle();

        // Random phases: mostly long continuing runs on small and mid boards,
        // with occasional restarts and a few short visits to large boards.
        sent = 0;
        while (sent < 400) begin
            settle();
            if ($urandom_range(0, 4) != 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    size_pick = '0;
                else if (pick < 10)
                    size_pick = BOARD_W'($urandom_range(1, 3));
                else if (pick < 60)
                    size_pick = BOARD_W'($urandom_range(4, 8));
                else if (pick < 86)
                    size_pick = BOARD_W'($urandom_range(9, 10));
                else if (pick < 95)
                    size_pick = BOARD_W'($urandom_range(11, 15));
                else
                    size_pick = BOARD_W'($urandom_range(16, 31));
                write_board_size(size_pick);
            end
            if (sb.board_rows() <= 10)
                count = $urandom_range(5, 40);
            else if (sb.board_rows() < 16)
                count = $urandom_range(1, 4);
            else
                count = $urandom_range(1, 2);
            repeat (count) begin
                send_request($urandom_range(0, 9) == 0);
                sent++;
                calm = (sent >= 340);
            end
        end

        settle();
        repeat (64) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
